/* rtl/llj_pkg.sv */
// Shared types and constants for the least-loaded job scheduler.
// No dependencies; imported by the top level, the checker and the testbench.
`timescale 1ns / 1ps

package llj_pkg;

  parameter int MAX_MACHINES_DEF = 16;

  parameter int LOAD_W  = 32;
  parameter int CNT_W   = 5;
  parameter int START_W = 31;
  parameter int ID_W    = 16;
  parameter int DUR_W   = 16;
  parameter int MNUM_W  = 5;
  parameter int APB_AW  = 3;
  parameter int APB_DW  = 32;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE,
    ST_SPAN,
    ST_OUT
  } llj_state_e;

  typedef enum logic {
    REG_MACHINE_COUNT = 1'b0,
    REG_START_TIME    = 1'b1
  } llj_reg_e;

endpackage

/* rtl/llj_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; holds the per-machine loads of the scheduler.
`timescale 1ns / 1ps

module llj_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/least_loaded_job_scheduler.sv */
// Least-loaded job scheduler: top level with sequencer, compare unit and register port.
// Depends on llj_pkg and llj_ram.
`timescale 1ns / 1ps

// Greedy list scheduler. Each accepted item is a job; it goes to the machine with the
// smallest load (finish time) among the first machine_count machines, ties to the lowest
// index. One comparator walks the loads held in a RAM, one machine per cycle. The effective
// machine count treats 0 as 1 and values above MAX_MACHINES as MAX_MACHINES. A job marked
// last passes through an extra state, ST_SPAN, that forms the makespan and reloads the loads.
// in_stall_o stays high from acceptance until the result has been taken. Writing either
// register reloads every load to start_time; reload is done by clearing per-machine valid
// bits, so the RAM itself is not rewritten.

module least_loaded_job_scheduler #(
  parameter int MAX_MACHINES = llj_pkg::MAX_MACHINES_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // APB register port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [llj_pkg::APB_AW-1:0]  paddr,
  input  logic [llj_pkg::APB_DW-1:0]  pwdata,
  output logic [llj_pkg::APB_DW-1:0]  prdata,
  output logic                        pready,
  // job input
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [llj_pkg::ID_W-1:0]    job_id_i,
  input  logic [llj_pkg::DUR_W-1:0]   job_duration_i,
  input  logic                        last_job_i,
  // result output
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [llj_pkg::ID_W-1:0]    assigned_job_o,
  output logic [llj_pkg::MNUM_W-1:0]  chosen_machine_o,
  output logic [llj_pkg::LOAD_W-1:0]  job_start_o,
  output logic                        batch_done_o,
  output logic [llj_pkg::LOAD_W-1:0]  makespan_o
);

  import llj_pkg::*;

  localparam int IW = (MAX_MACHINES > 1) ? $clog2(MAX_MACHINES) : 1;
  localparam int CW = $clog2(MAX_MACHINES + 1);

  llj_state_e state_q, state_d;

  logic [CNT_W-1:0]   count_q;
  logic [START_W-1:0] start_q;
  logic [MAX_MACHINES-1:0] valid_q;

  logic [ID_W-1:0]   job_id_q;
  logic [DUR_W-1:0]  dur_q;
  logic              last_q;
  logic [CW-1:0]     idx_q;
  logic [IW-1:0]     best_q;
  logic [LOAD_W-1:0] best_load_q;
  logic [LOAD_W-1:0] max_q;
  logic              vld_rd_q;
  logic [MNUM_W-1:0] mnum_q;
  logic [LOAD_W-1:0] span_q;

  logic              cfg_we;
  llj_reg_e          cfg_reg;
  logic [CW-1:0]     n_eff;
  logic              in_acc;
  logic              out_acc;
  logic [IW-1:0]     raddr;
  logic [IW-1:0]     pos;
  logic [LOAD_W-1:0] rdata;
  logic [LOAD_W-1:0] load_eff;
  logic [LOAD_W:0]   sum;
  logic [LOAD_W-1:0] new_load;
  logic              ram_we;

  // ---------------------------------------------------------------- register port
  assign pready  = 1'b1;
  assign cfg_reg = llj_reg_e'(paddr[2]);
  assign cfg_we  = psel & penable & pwrite;

  always_comb begin
    case (cfg_reg)
      REG_MACHINE_COUNT: prdata = APB_DW'(count_q);
      REG_START_TIME:    prdata = APB_DW'(start_q);
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= CNT_W'(1);
      start_q <= '0;
    end else if (cfg_we) begin
      case (cfg_reg)
        REG_MACHINE_COUNT: count_q <= pwdata[CNT_W-1:0];
        REG_START_TIME:    start_q <= pwdata[START_W-1:0];
        default:           ;
      endcase
    end
  end

  // clamp to 1..MAX_MACHINES
  always_comb begin
    if (count_q == '0) begin
      n_eff = CW'(1);
    end else if (32'(count_q) > 32'(MAX_MACHINES)) begin
      n_eff = CW'(MAX_MACHINES);
    end else begin
      n_eff = CW'(count_q);
    end
  end

  // ---------------------------------------------------------------- sequencer
  assign in_acc  = in_valid_i & ~in_stall_o;
  assign out_acc = out_valid_o & ~out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (in_acc) state_d = ST_SCAN;
      ST_SCAN:   if (idx_q == n_eff) state_d = ST_UPDATE;
      ST_UPDATE: state_d = last_q ? ST_SPAN : ST_OUT;
      ST_SPAN:   state_d = ST_OUT;
      ST_OUT:    if (out_acc) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = (state_q == ST_OUT);

  // ---------------------------------------------------------------- load store
  // read address leads the compare: the registered RAM read returns its data in the next cycle
  assign raddr    = (state_q == ST_SCAN) ? idx_q[IW-1:0] : '0;
  assign pos      = IW'(idx_q - CW'(1));
  assign load_eff = vld_rd_q ? rdata : LOAD_W'(start_q);

  assign sum      = (LOAD_W+1)'(best_load_q) + (LOAD_W+1)'(dur_q);
  assign new_load = sum[LOAD_W] ? '1 : sum[LOAD_W-1:0];
  assign ram_we   = (state_q == ST_UPDATE);

  llj_ram #(
    .WIDTH (LOAD_W),
    .DEPTH (MAX_MACHINES),
    .AW    (IW)
  ) u_load_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (best_q),
    .wdata_i (new_load),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // a cleared valid bit means the machine is still at start_time
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      max_q    <= '0;
      vld_rd_q <= 1'b0;
    end else begin
      vld_rd_q <= valid_q[raddr];
      if (cfg_we) begin
        valid_q <= '0;
        if (cfg_reg == REG_START_TIME) begin
          max_q <= LOAD_W'(pwdata[START_W-1:0]);
        end else begin
          max_q <= LOAD_W'(start_q);
        end
      end else if (state_q == ST_UPDATE) begin
        valid_q[best_q] <= 1'b1;
        if (new_load > max_q) begin
          max_q <= new_load;
        end
      end else if (state_q == ST_SPAN) begin
        valid_q <= '0;
        max_q   <= LOAD_W'(start_q);
      end
    end
  end

  // ---------------------------------------------------------------- datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          job_id_q    <= job_id_i;
          dur_q       <= job_duration_i;
          last_q      <= last_job_i;
          idx_q       <= CW'(1);
          best_q      <= '0;
          best_load_q <= '1;
        end
      end
      ST_SCAN: begin
        // strict compare keeps the lowest index on ties
        if (load_eff < best_load_q) begin
          best_q      <= pos;
          best_load_q <= load_eff;
        end
        idx_q <= idx_q + CW'(1);
      end
      ST_UPDATE: begin
        mnum_q <= MNUM_W'(32'(best_q) + 32'd1);
        span_q <= '0;
      end
      ST_SPAN: begin
        span_q <= max_q - LOAD_W'(start_q);
      end
      default: ;
    endcase
  end

  assign assigned_job_o   = job_id_q;
  assign chosen_machine_o = mnum_q;
  assign job_start_o      = best_load_q;
  assign batch_done_o     = last_q;
  assign makespan_o       = span_q;

endmodule

/* rtl/llj_checker.sv */
// Port-level checks for the least-loaded job scheduler, bound to the top level.
// Depends on llj_pkg and least_loaded_job_scheduler.
`timescale 1ns / 1ps

module llj_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        in_stall_o,
  input  logic                        out_valid_o,
  input  logic                        out_stall_i,
  input  logic [llj_pkg::ID_W-1:0]    assigned_job_o,
  input  logic [llj_pkg::MNUM_W-1:0]  chosen_machine_o,
  input  logic [llj_pkg::LOAD_W-1:0]  job_start_o,
  input  logic                        batch_done_o,
  input  logic [llj_pkg::LOAD_W-1:0]  makespan_o
);

  import llj_pkg::*;

  // a held result keeps its item
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(assigned_job_o) &&
      $stable(chosen_machine_o) && $stable(job_start_o) && $stable(makespan_o))
    else $error("result changed while stalled");

  a_span_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !batch_done_o |-> makespan_o == '0)
    else $error("makespan set on a job that is not last");

  // no result can appear the cycle after acceptance: the scan takes at least one step
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o && !out_valid_o)
    else $error("block not busy after accepting an item");

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input open while a result is pending");

endmodule

bind least_loaded_job_scheduler llj_checker u_llj_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_stall_o       (in_stall_o),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .assigned_job_o   (assigned_job_o),
  .chosen_machine_o (chosen_machine_o),
  .job_start_o      (job_start_o),
  .batch_done_o     (batch_done_o),
  .makespan_o       (makespan_o)
);

/* test/least_loaded_job_scheduler_tb.sv */
// Self-checking testbench for least_loaded_job_scheduler: directed table, random batches,
// a top-start-time run and back-pressure, checked against pinned values or an in-bench predictor.
// Depends on rtl/llj_pkg.sv and the block's RTL.
`timescale 1ns / 1ps

module least_loaded_job_scheduler_tb;
  import llj_pkg::*;

  localparam int MACHINES    = MAX_MACHINES_DEF;
  localparam int CYCLE_LIMIT = 5_000_000;
  localparam int SHOW_MAX    = 10;

  typedef struct packed {
    logic [ID_W-1:0]   job;
    logic [MNUM_W-1:0] machine;
    logic [LOAD_W-1:0] start_at;
    logic              done;
    logic [LOAD_W-1:0] span;
  } sched_res_t;

  typedef enum bit {ROW_JOB, ROW_WRITE} row_kind_e;

  typedef struct {
    row_kind_e  kind;
    llj_reg_e   regsel;
    bit [31:0]  wdata;
    bit [15:0]  id;
    bit [15:0]  dur;
    bit         last;
    bit         pinned;
    sched_res_t want;
  } plan_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [APB_AW-1:0]   paddr = '0;
  logic [APB_DW-1:0]   pwdata = '0;
  logic [APB_DW-1:0]   prdata;
  logic                pready;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic [ID_W-1:0]     job_id_i = '0;
  logic [DUR_W-1:0]    job_duration_i = '0;
  logic                last_job_i = 1'b0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [ID_W-1:0]     assigned_job_o;
  logic [MNUM_W-1:0]   chosen_machine_o;
  logic [LOAD_W-1:0]   job_start_o;
  logic                batch_done_o;
  logic [LOAD_W-1:0]   makespan_o;

  least_loaded_job_scheduler u_dut (
    .clk_i, .rst_ni,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid_i, .in_stall_o, .job_id_i, .job_duration_i, .last_job_i,
    .out_valid_o, .out_stall_i, .assigned_job_o, .chosen_machine_o,
    .job_start_o, .batch_done_o, .makespan_o
  );

  always #6 clk_i = ~clk_i;

  // predictor state
  bit [LOAD_W-1:0]  mload [MACHINES];
  bit [CNT_W-1:0]   mc_reg = 5'd1;
  bit [START_W-1:0] st_reg = '0;

  sched_res_t due_assignments[$];
  plan_row_t  plan[$];

  int err_cnt = 0;
  int results_seen = 0;
  int jobs_offered = 0;
  int batches_closed = 0;
  int reg_writes = 0;
  int cycles = 0;

  // flow-control knobs
  bit tx_quiet = 1'b0;
  bit rx_quiet = 1'b0;
  int tx_calm = 0;
  int rx_calm = 0;
  int rx_left = 0;
  int rx_hold_req = 0;

  function automatic int eff_count();
    if (mc_reg == 0) return 1;
    if (mc_reg > MACHINES) return MACHINES;
    return int'(mc_reg);
  endfunction

  function automatic void reload_loads();
    foreach (mload[i]) mload[i] = {1'b0, st_reg};
  endfunction

  function automatic void apply_reg(llj_reg_e r, bit [31:0] v);
    case (r)
      REG_MACHINE_COUNT: mc_reg = v[CNT_W-1:0];
      REG_START_TIME:    st_reg = v[START_W-1:0];
      default: ;
    endcase
    reload_loads();
  endfunction

  // Greedy least-loaded pick, ties to lowest index, saturating add; last job: makespan, reload.
  function automatic sched_res_t schedule_job(bit [15:0] id, bit [15:0] dur, bit last);
    sched_res_t r;
    int n;
    int pick;
    bit [LOAD_W:0]   sum;
    bit [LOAD_W-1:0] peak;
    n = eff_count();
    pick = 0;
    for (int i = 1; i < n; i++)
      if (mload[i] < mload[pick]) pick = i;
    r.job      = id;
    r.machine  = MNUM_W'(pick + 1);
    r.start_at = mload[pick];
    r.done     = last;
    r.span     = '0;
    sum = {1'b0, mload[pick]} + dur;
    mload[pick] = sum[LOAD_W] ? '1 : sum[LOAD_W-1:0];
    if (last) begin
      peak = '0;
      for (int i = 0; i < n; i++)
        if (mload[i] > peak) peak = mload[i];
      r.span = (peak >= {1'b0, st_reg}) ? peak - {1'b0, st_reg} : '0;
      reload_loads();
    end
    return r;
  endfunction

  function automatic plan_row_t job_row(bit [15:0] id, bit [15:0] dur, bit last);
    plan_row_t p;
    p = '{kind: ROW_JOB, regsel: REG_MACHINE_COUNT, wdata: '0, id: id, dur: dur,
          last: last, pinned: 1'b0, want: '0};
    return p;
  endfunction

  function automatic plan_row_t pinned_row(bit [15:0] id, bit [15:0] dur, bit last,
                                           bit [4:0] mach, bit [31:0] start, bit [31:0] span);
    plan_row_t p;
    p = job_row(id, dur, last);
    p.pinned = 1'b1;
    p.want   = '{job: id, machine: mach, start_at: start, done: last, span: span};
    return p;
  endfunction

  function automatic plan_row_t write_row(llj_reg_e r, bit [31:0] v);
    plan_row_t p;
    p = job_row('0, '0, 1'b0);
    p.kind   = ROW_WRITE;
    p.regsel = r;
    p.wdata  = v;
    return p;
  endfunction

  task automatic note_error(string msg);
    err_cnt++;
    if (err_cnt <= SHOW_MAX) $display("%s", msg);
  endtask

  task automatic check_field(string name, logic [31:0] e, logic [31:0] a);
    if (a !== e)
      note_error($sformatf("result %0d: %s expected %h, got %h", results_seen, name, e, a));
  endtask

  // Mostly back-to-back, some short gaps, the odd long one, with quiet stretches.
  function automatic int pick_gap();
    int r;
    if (tx_quiet) return 0;
    if (tx_calm > 0) begin
      tx_calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      tx_calm = $urandom_range(20, 80);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic offer_job(bit [15:0] id, bit [15:0] dur, bit last, bit pinned,
                           sched_res_t want);
    int gap;
    sched_res_t guess;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i     <= 1'b1;
    job_id_i       <= id;
    job_duration_i <= dur;
    last_job_i     <= last;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    guess = schedule_job(id, dur, last);
    due_assignments.push_back(pinned ? want : guess);
    jobs_offered++;
    if (last) batches_closed++;
  endtask

  task automatic offer_random(bit last);
    bit [15:0] dur;
    case ($urandom_range(0, 9))
      0:       dur = '0;
      1:       dur = '1;
      2, 3, 4: dur = 16'($urandom_range(0, 3));   // small values give plenty of ties
      default: dur = 16'($urandom());
    endcase
    offer_job(16'($urandom()), dur, last, 1'b0, '0);
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (due_assignments.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(llj_reg_e r, bit [31:0] v);
    drain();
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= v;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    apply_reg(r, v);
    reg_writes++;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // result side back-pressure
  always @(negedge clk_i) begin : rx_stall_gen
    int r;
    if (rx_hold_req > 0) begin
      rx_left     = rx_hold_req;
      rx_hold_req = 0;
    end
    if (rx_left > 0) begin
      out_stall_i <= 1'b1;
      rx_left--;
    end else if (rx_calm > 0 || rx_quiet) begin
      out_stall_i <= 1'b0;
      if (rx_calm > 0) rx_calm--;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 60) begin
        out_stall_i <= 1'b0;
      end else if (r < 62) begin
        rx_calm = $urandom_range(30, 120);
        out_stall_i <= 1'b0;
      end else if (r < 92) begin
        rx_left = $urandom_range(0, 2);
        out_stall_i <= 1'b1;
      end else begin
        rx_left = $urandom_range(8, 40);
        out_stall_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : result_mon
    sched_res_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (due_assignments.size() == 0) begin
        note_error($sformatf("unexpected result: job %h machine %0d", assigned_job_o,
                             chosen_machine_o));
      end else begin
        want = due_assignments.pop_front();
        check_field("assigned_job", 32'(want.job), 32'(assigned_job_o));
        check_field("chosen_machine", 32'(want.machine), 32'(chosen_machine_o));
        check_field("job_start", want.start_at, job_start_o);
        check_field("batch_done", 32'(want.done), 32'(batch_done_o));
        check_field("makespan", want.span, makespan_o);
      end
      results_seen++;
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               due_assignments.size());
      $display("least_loaded_job_scheduler_tb: errors");
      $finish;
    end
  end

  initial begin : stimulus
    int n;
    int len;
    int sent;
    bit [31:0] v;
    reload_loads();

    // after reset: one machine, start at 0
    plan.push_back(pinned_row(16'h0000, 16'h0000, 1'b0, 5'd1, 32'd0, 32'd0));
    plan.push_back(pinned_row(16'hFFFF, 16'hFFFF, 1'b1, 5'd1, 32'd0, 32'h0000_FFFF));
    plan.push_back(write_row(REG_MACHINE_COUNT, 32'd4));
    plan.push_back(pinned_row(16'd1, 16'd10, 1'b0, 5'd1, 32'd0, 32'd0));
    plan.push_back(pinned_row(16'd2, 16'd5, 1'b0, 5'd2, 32'd0, 32'd0));
    plan.push_back(pinned_row(16'd3, 16'd5, 1'b0, 5'd3, 32'd0, 32'd0));
    plan.push_back(pinned_row(16'd4, 16'd0, 1'b0, 5'd4, 32'd0, 32'd0));
    plan.push_back(pinned_row(16'd5, 16'd7, 1'b0, 5'd4, 32'd0, 32'd0));
    plan.push_back(pinned_row(16'd6, 16'd1, 1'b1, 5'd2, 32'd5, 32'd10));
    // zero count behaves as one machine
    plan.push_back(write_row(REG_MACHINE_COUNT, 32'd0));
    plan.push_back(pinned_row(16'd7, 16'd3, 1'b0, 5'd1, 32'd0, 32'd0));
    plan.push_back(pinned_row(16'd8, 16'd4, 1'b1, 5'd1, 32'd3, 32'd7));
    // count above the maximum clamps
    plan.push_back(write_row(REG_MACHINE_COUNT, 32'd31));
    plan.push_back(pinned_row(16'd9, 16'd2, 1'b0, 5'd1, 32'd0, 32'd0));
    plan.push_back(pinned_row(16'd10, 16'd1, 1'b0, 5'd2, 32'd0, 32'd0));
    plan.push_back(pinned_row(16'd11, 16'd0, 1'b1, 5'd3, 32'd0, 32'd2));
    // top bit of start_time is dropped
    plan.push_back(write_row(REG_START_TIME, 32'hFFFF_FFFF));
    plan.push_back(pinned_row(16'd12, 16'hFFFF, 1'b1, 5'd1, 32'h7FFF_FFFF, 32'h0000_FFFF));
    plan.push_back(write_row(REG_MACHINE_COUNT, 32'd3));
    plan.push_back(pinned_row(16'd13, 16'd9, 1'b0, 5'd1, 32'h7FFF_FFFF, 32'd0));
    // register write mid-batch starts a new batch
    plan.push_back(write_row(REG_START_TIME, 32'd100));
    plan.push_back(pinned_row(16'd14, 16'd1, 1'b0, 5'd1, 32'd100, 32'd0));
    plan.push_back(pinned_row(16'd15, 16'd2, 1'b1, 5'd2, 32'd100, 32'd2));
    plan.push_back(write_row(REG_MACHINE_COUNT, 32'd17));
    plan.push_back(job_row(16'hA5A5, 16'h5A5A, 1'b0));
    plan.push_back(job_row(16'h5A5A, 16'hA5A5, 1'b0));
    plan.push_back(job_row(16'h8001, 16'h7FFE, 1'b1));

    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE) write_reg(plan[i].regsel, plan[i].wdata);
      else offer_job(plan[i].id, plan[i].dur, plan[i].last, plan[i].pinned, plan[i].want);
    end

    // random batches under a spread of settings
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin write_reg(REG_START_TIME, 32'd0);        write_reg(REG_MACHINE_COUNT, 32'd1);  end
        1: begin write_reg(REG_START_TIME, 32'h7FFF_FFFF); write_reg(REG_MACHINE_COUNT, 32'd16); end
        2: begin write_reg(REG_START_TIME, $urandom());   write_reg(REG_MACHINE_COUNT, 32'd0);  end
        3: begin write_reg(REG_MACHINE_COUNT, 32'd31);    write_reg(REG_START_TIME, $urandom()); end
        4: begin write_reg(REG_START_TIME, 32'd0);        write_reg(REG_MACHINE_COUNT, 32'd2);  end
        5: begin
          write_reg(REG_START_TIME, $urandom_range(0, 1000));
          write_reg(REG_MACHINE_COUNT, $urandom_range(3, 15));
        end
        6: begin
          v = ($urandom() & ~32'h1F) | 32'd17;   // junk above the count field
          write_reg(REG_MACHINE_COUNT, v);
          write_reg(REG_START_TIME, $urandom_range(0, 100));
        end
        default: begin
          write_reg(REG_MACHINE_COUNT, $urandom_range(0, 31));
          write_reg(REG_START_TIME, $urandom());
        end
      endcase

      if (ph == 3) begin
        // long receiver hold-off while the sender keeps pushing
        rx_hold_req = 250;
        tx_quiet = 1'b1;
        repeat (12) offer_random(1'b0);
        tx_quiet = 1'b0;
      end

      sent = 0;
      while (sent < 100) begin
        n = eff_count();
        len = $urandom_range(1, 3 * n + 2);
        for (int k = 0; k < len; k++) offer_random(k == len - 1);
        sent += len;
        case ($urandom_range(0, 29))
          0: drain();
          1: write_reg(REG_START_TIME, $urandom());
          default: ;
        endcase
      end
    end

    // one machine from the top start time, longest jobs back to back
    tx_quiet = 1'b1;
    rx_quiet = 1'b1;
    write_reg(REG_MACHINE_COUNT, 32'd1);
    write_reg(REG_START_TIME, 32'h7FFF_FFFF);
    repeat (6) offer_job(16'($urandom()), 16'hFFFF, 1'b0, 1'b0, '0);
    repeat (3) offer_random(1'b0);
    offer_random(1'b1);
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;

    drain();
    repeat (40) @(posedge clk_i);
    if (due_assignments.size() != 0)
      note_error($sformatf("%0d results never arrived", due_assignments.size()));

    $display("%0d jobs in %0d closed batches, %0d register writes, %0d results checked",
             jobs_offered, batches_closed, reg_writes, results_seen);
    $display("counts 0..31 incl. clamping, start time extremes, long jobs, hold-off");
    if (err_cnt == 0) begin
      $display("least_loaded_job_scheduler_tb: clean");
    end else begin
      $display("%0d mismatches", err_cnt);
      $display("least_loaded_job_scheduler_tb: errors");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/llj_pkg.sv
rtl/llj_ram.sv
rtl/least_loaded_job_scheduler.sv
rtl/llj_checker.sv
test/least_loaded_job_scheduler_tb.sv
